[src/pcra_pkg.sv]
`timescale 1ns / 1ps
package pcra_pkg;

	localparam int FRAMES_DEF   = 8;
	localparam int AGE_BITS_DEF = 16;
	localparam int PAGE_W       = 16;
	localparam int FRAME_W      = 3;
	localparam int IDX_MAX_W    = 6;
	localparam int AGE_MAX_W    = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} pcra_state_t;

	// search word handed from cell to cell
	typedef struct packed {
		logic                 vld;
		logic [PAGE_W-1:0]    page;
		logic                 hit;
		logic [IDX_MAX_W-1:0] hit_idx;
		logic                 vic_found;
		logic [IDX_MAX_W-1:0] vic_idx;
		logic [AGE_MAX_W-1:0] vic_age;
		logic [PAGE_W-1:0]    vic_page;
		logic                 glob_found;
		logic [IDX_MAX_W-1:0] glob_idx;
		logic [AGE_MAX_W-1:0] glob_age;
		logic [PAGE_W-1:0]    glob_page;
	} pcra_tok_t;

	// update broadcast to every cell
	typedef struct packed {
		logic                 en;
		logic                 hit;
		logic                 full;
		logic [IDX_MAX_W-1:0] idx;
		logic [IDX_MAX_W-1:0] glob_idx;
		logic [PAGE_W-1:0]    page;
	} pcra_cmt_t;

endpackage

[src/pcra_in_if.sv]
`timescale 1ns / 1ps
interface pcra_in_if;
	import pcra_pkg::*;
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

[src/pcra_out_if.sv]
`timescale 1ns / 1ps
interface pcra_out_if;
	import pcra_pkg::*;
	logic               valid;
	logic               ready;
	logic               hit;
	logic [FRAME_W-1:0] frame;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;

	modport source (output valid, output hit, output frame, output evicted_valid,
		output evicted_page, input ready);
	modport sink (input valid, input hit, input frame, input evicted_valid,
		input evicted_page, output ready);
endinterface

[src/pcra_cell.sv]
`timescale 1ns / 1ps
module pcra_cell import pcra_pkg::*; #(
	parameter int AGE_BITS = AGE_BITS_DEF,
	parameter int IDX      = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pcra_tok_t tok_in,
	output pcra_tok_t tok_out,
	input  pcra_cmt_t cmt
);

	localparam logic [AGE_BITS-1:0] AGE_TOP = {AGE_BITS{1'b1}};
	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

	logic [PAGE_W-1:0]    page_q;
	logic [AGE_BITS-1:0]  age_q;
	logic                 ref_q;
	logic                 filled_q;
	logic [AGE_MAX_W-1:0] age_ext;
	pcra_tok_t            tok_nxt;
	pcra_tok_t            tok_q;
	logic                 sel;
	logic                 gsel;
	logic                 fill_new;
	logic                 evict_here;
	logic                 filled_nxt;

	assign age_ext = AGE_MAX_W'(age_q);

	always_comb begin
		tok_nxt = tok_in;
		if (filled_q && !tok_in.hit && page_q == tok_in.page) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_idx = MY_IDX;
		end
		if (!ref_q && (!tok_in.vic_found || age_ext > tok_in.vic_age)) begin
			tok_nxt.vic_found = 1'b1;
			tok_nxt.vic_idx   = MY_IDX;
			tok_nxt.vic_age   = age_ext;
			tok_nxt.vic_page  = page_q;
		end
		if (!tok_in.glob_found || age_ext > tok_in.glob_age) begin
			tok_nxt.glob_found = 1'b1;
			tok_nxt.glob_idx   = MY_IDX;
			tok_nxt.glob_age   = age_ext;
			tok_nxt.glob_page  = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

	assign sel        = cmt.idx == MY_IDX;
	assign gsel       = cmt.glob_idx == MY_IDX;
	assign fill_new   = cmt.en && sel && !cmt.hit && !cmt.full;
	assign evict_here = cmt.en && sel && !cmt.hit && cmt.full;
	assign filled_nxt = filled_q || fill_new;

	always_ff @(posedge clk) begin
		if (fill_new || evict_here) begin
			page_q <= cmt.page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q    <= AGE_BITS'(1);
			ref_q    <= 1'b0;
			filled_q <= 1'b0;
		end else if (cmt.en) begin
			filled_q <= filled_nxt;
			if (cmt.hit && sel) begin
				ref_q <= 1'b1;
			end else if (fill_new) begin
				ref_q <= 1'b0;
			end else if (!cmt.hit && cmt.full && gsel) begin
				ref_q <= 1'b0;
			end
			if (evict_here) begin
				age_q <= AGE_BITS'(1);
			end else if (filled_nxt && age_q != AGE_TOP) begin
				age_q <= age_q + AGE_BITS'(1);
			end
		end
	end

endmodule

[src/page_replacement_ref_aging.sv]
`timescale 1ns / 1ps
// An accepted lookup word is registered, then walks the chain of frame cells
// one cell per cycle; the update is committed when the result register is
// free. A new lookup is taken only after the previous one has committed.
// Reset: all frames empty, ages 1, reference bits clear; page entries are
// left as they are until filled.
module page_replacement_ref_aging import pcra_pkg::*; #(
	parameter int FRAMES   = FRAMES_DEF,
	parameter int AGE_BITS = AGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	pcra_in_if.sink           lookup,
	pcra_out_if.source        result
);

	localparam int FILL_W = $clog2(FRAMES + 1);

	pcra_state_t        state_q;
	pcra_state_t        state_nxt;
	pcra_tok_t          tok [FRAMES+1];
	pcra_tok_t          launch_nxt;
	pcra_tok_t          launch_q;
	pcra_tok_t          end_q;
	pcra_cmt_t          cmt;
	logic [FILL_W-1:0]  fill_count_q;
	logic               full;
	logic               slot_free;
	logic               accept;
	logic               commit;
	logic [IDX_MAX_W-1:0] tgt_idx;
	logic [IDX_MAX_W-1:0] glob_idx;

	logic               out_vld_q;
	logic               out_hit_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_ev_q;
	logic [PAGE_W-1:0]  out_evp_q;

	assign full      = fill_count_q == FILL_W'(FRAMES);
	assign slot_free = !out_vld_q || result.ready;

	always_comb begin
		state_nxt    = state_q;
		lookup.ready = 1'b0;
		commit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				lookup.ready = 1'b1;
				if (lookup.valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tok[FRAMES].vld) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (slot_free) begin
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign accept = lookup.valid && lookup.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		launch_nxt      = '0;
		launch_nxt.vld  = accept;
		launch_nxt.page = lookup.page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else begin
			launch_q <= launch_nxt;
		end
	end

	assign tok[0] = launch_q;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		pcra_cell #(
			.AGE_BITS (AGE_BITS),
			.IDX      (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.cmt     (cmt)
		);
	end

	always_ff @(posedge clk) begin
		if (tok[FRAMES].vld) begin
			end_q <= tok[FRAMES];
		end
	end

	assign glob_idx = end_q.glob_found ? end_q.glob_idx : '0;

	always_comb begin
		if (end_q.hit) begin
			tgt_idx = end_q.hit_idx;
		end else if (!full) begin
			tgt_idx = IDX_MAX_W'(fill_count_q);
		end else if (end_q.vic_found) begin
			tgt_idx = end_q.vic_idx;
		end else begin
			tgt_idx = glob_idx;
		end
	end

	assign cmt.en       = commit;
	assign cmt.hit      = end_q.hit;
	assign cmt.full     = full;
	assign cmt.idx      = tgt_idx;
	assign cmt.glob_idx = glob_idx;
	assign cmt.page     = end_q.page;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (commit && !end_q.hit && !full) begin
			fill_count_q <= fill_count_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q   <= end_q.hit;
			out_frame_q <= tgt_idx[FRAME_W-1:0];
			out_ev_q    <= !end_q.hit && full;
			if (!end_q.hit && full) begin
				out_evp_q <= end_q.vic_found ? end_q.vic_page : end_q.glob_page;
			end else begin
				out_evp_q <= '0;
			end
		end
	end

	assign result.valid         = out_vld_q;
	assign result.hit           = out_hit_q;
	assign result.frame         = out_frame_q;
	assign result.evicted_valid = out_ev_q;
	assign result.evicted_page  = out_evp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FILL_W'(FRAMES))
		else $error("fill count beyond frame count");

	a_load_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_WAIT))
		else $error("result word loaded outside the update cycle");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.evicted_valid |-> !result.hit)
		else $error("eviction reported on a hit");

	a_chain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !launch_q.vld && !tok[FRAMES].vld)
		else $error("search word in flight while idle");

endmodule

[dv/page_replacement_ref_aging_tb.sv]
`timescale 1ns / 1ps

typedef struct packed {
	logic                         hit;
	logic [pcra_pkg::FRAME_W-1:0] frame;
	logic                         evicted_valid;
	logic [pcra_pkg::PAGE_W-1:0]  evicted_page;
} frame_outcome_t;

class page_aging_scoreboard;
	localparam int AW = pcra_pkg::AGE_BITS_DEF;

	logic [pcra_pkg::PAGE_W-1:0]       pages [pcra_pkg::FRAMES_DEF];
	logic [pcra_pkg::AGE_BITS_DEF-1:0] ages [pcra_pkg::FRAMES_DEF];
	bit                                refs [pcra_pkg::FRAMES_DEF];
	int                                filled;
	frame_outcome_t                    due_words [$];
	int unsigned                       errors;

	function new();
		for (int i = 0; i < pcra_pkg::FRAMES_DEF; i++) begin
			pages[i] = '0;
			ages[i]  = AW'(1);
			refs[i]  = 1'b0;
		end
		filled = 0;
		errors = 0;
	endfunction

	function int oldest(bit skip_referenced);
		int best;
		logic [pcra_pkg::AGE_BITS_DEF-1:0] best_age;
		best     = -1;
		best_age = '0;
		for (int i = 0; i < pcra_pkg::FRAMES_DEF; i++) begin
			if (!(skip_referenced && refs[i]) && (best < 0 || ages[i] > best_age)) begin
				best     = i;
				best_age = ages[i];
			end
		end
		return best;
	endfunction

	function void note_lookup(logic [pcra_pkg::PAGE_W-1:0] pg);
		int hit_at;
		int where;
		int victim;
		int glob;
		frame_outcome_t o;
		hit_at = -1;
		where  = 0;
		o      = '0;
		for (int i = 0; i < filled; i++) begin
			if (hit_at < 0 && pages[i] == pg)
				hit_at = i;
		end
		if (hit_at >= 0) begin
			refs[hit_at] = 1'b1;
			o.hit        = 1'b1;
			where        = hit_at;
		end else if (filled < pcra_pkg::FRAMES_DEF) begin
			where        = filled;
			pages[where] = pg;
			refs[where]  = 1'b0;
			filled++;
		end else begin
			// judge both candidates on the ages before this word
			victim = oldest(1'b1);
			glob   = oldest(1'b0);
			if (victim < 0)
				victim = glob;
			o.evicted_valid = 1'b1;
			o.evicted_page  = pages[victim];
			pages[victim]   = pg;
			ages[victim]    = '0;
			refs[glob]      = 1'b0;
			where           = victim;
		end
		for (int i = 0; i < filled; i++) begin
			if (ages[i] != '1)
				ages[i] = ages[i] + 1'b1;
		end
		o.frame = where[pcra_pkg::FRAME_W-1:0];
		due_words.push_back(o);
	endfunction

	function void mismatch(string what, frame_outcome_t exp, frame_outcome_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected hit=%0b frame=%0d evicted=%0b page=%h, %s",
				$time, what, exp.hit, exp.frame, exp.evicted_valid, exp.evicted_page,
				$sformatf("got hit=%0b frame=%0d evicted=%0b page=%h",
					got.hit, got.frame, got.evicted_valid, got.evicted_page));
	endfunction

	function void check_result(frame_outcome_t got);
		frame_outcome_t exp;
		if (due_words.size() == 0) begin
			mismatch("unexpected word", '0, got);
		end else begin
			exp = due_words.pop_front();
			if (got.hit !== exp.hit || got.frame !== exp.frame
					|| got.evicted_valid !== exp.evicted_valid
					|| got.evicted_page !== exp.evicted_page)
				mismatch("result mismatch", exp, got);
		end
	endfunction
endclass

module page_replacement_ref_aging_tb;
	import pcra_pkg::*;

	localparam int N_RANDOM    = 650;
	localparam int POOL_SIZE   = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_GUARD = 20;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	pcra_in_if  lookup();
	pcra_out_if result();

	page_replacement_ref_aging u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.lookup (lookup),
		.result (result)
	);

	page_aging_scoreboard sb = new();

	bit                quiet;
	bit                burst;
	bit                hold_req;
	int                pool_span;
	logic [PAGE_W-1:0] pool [POOL_SIZE];
	int unsigned       cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PAGE_W-1:0] next_page();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return PAGE_W'($urandom_range(0, 65535));
		if (r < 12)
			pool[$urandom_range(0, POOL_SIZE - 1)] = PAGE_W'($urandom_range(0, 65535));
		return pool[$urandom_range(0, pool_span - 1)];
	endfunction

	task automatic send_page(input logic [PAGE_W-1:0] pg);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			lookup.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		lookup.valid <= 1'b1;
		lookup.page  <= pg;
		do
			@(posedge clk);
		while (!lookup.ready);
		sb.note_lookup(pg);
	endtask

	task automatic wait_all_results();
		lookup.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_words.size() != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int stall;
		frame_outcome_t got;
		stall = 0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				got.hit           = result.hit;
				got.frame         = result.frame;
				got.evicted_valid = result.evicted_valid;
				got.evicted_page  = result.evicted_page;
				sb.check_result(got);
			end
			if (stall > 0) begin
				stall--;
				result.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
				result.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				result.ready <= (stall == 0);
			end
		end
	end

	initial begin : sender
		logic [PAGE_W-1:0] warmup [$];
		lookup.valid <= 1'b0;
		lookup.page  <= '0;
		quiet     = 1'b0;
		burst     = 1'b0;
		hold_req  = 1'b0;
		pool_span = POOL_SIZE;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = PAGE_W'($urandom_range(0, 65535));

		// fill with a hit on the way, reference every frame, then evict
		warmup = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h00FF,
			16'hFF00, 16'h5555, 16'hAAAA,
			16'h0000, 16'h0001, 16'h8000, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA,
			16'h1234, 16'h4321, 16'h0000, 16'h4321};

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (warmup[i])
			send_page(warmup[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0)
				pool_span = $urandom_range(5, POOL_SIZE);
			quiet = (n >= 100 && n < 150);
			if (n == 200) begin
				hold_req = 1'b1;
				burst    = 1'b1;
			end
			if (n == 260)
				burst = 1'b0;
			if (n == 400)
				wait_all_results();
			send_page(next_page());
		end

		wait_all_results();
		repeat (DRAIN_GUARD) @(posedge clk);
		if (sb.errors == 0 && sb.due_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

[files.f]
src/pcra_pkg.sv
src/pcra_in_if.sv
src/pcra_out_if.sv
src/pcra_cell.sv
src/page_replacement_ref_aging.sv
dv/page_replacement_ref_aging_tb.sv
